FILE: hw/rtl/sgc_pkg.sv
// Shared types, command codes and default sizes for the Sobol point generator.
`default_nettype none
package sgc_pkg;

  localparam int DEF_MAX_DIMS = 8;
  localparam int DEF_DIR_BITS = 32;

  localparam logic [3:0] DIMS_RESET = 4'd8;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_NEXT    = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  dim_select;
    logic [5:0]  bit_position;
    logic [31:0] direction_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  coord_dim;
    logic [31:0] coord_value;
    logic        last_coord;
    logic        exhausted;
  } out_item_t;

  // Control handed to every accumulator cell of the ring; mix reaches only the head cell.
  typedef struct packed {
    logic clear;
    logic shift;
    logic mix;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/sgc_cell.sv
// One accumulator cell of the rotating ring; the head cell also folds in a direction word.
`default_nettype none
module sgc_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sgc_pkg::cell_ctrl_t ctrl,
  input  wire logic [31:0]        mix_word,
  input  wire logic [31:0]        din,
  output logic      [31:0]        dout
);

  logic [31:0] acc_r;
  logic [31:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.shift) begin
      acc_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign dout = ctrl.mix ? (acc_r ^ mix_word) : acc_r;

endmodule
`default_nettype wire

FILE: hw/rtl/sobol_gray_code_point_generator.sv
// Sobol point generator, Gray-code update: top level with sequencer and cell ring.
//
// Usage:
//   Input requests (in_valid/in_stall/in_data) carry one command each: load a
//   direction word, restart the sequence, or generate the next point. The
//   configuration port (cfg_valid/cfg_ready/cfg_data) sets the number of
//   dimensions per point and is always ready.
//   A load or restart does not stall the input and produces no result. A next-point
//   request yields one result request per active dimension, dimension 0 first,
//   with last_coord on the final one. The coordinates then enter the output
//   register one per cycle while the output is not stalled.
//   The accumulators sit in a ring of MAX_DIMS cells that rotates once per
//   point, one cell per cycle; a step that emits a coordinate waits while the
//   receiver stalls a pending result, as does the table read. The input stays
//   stalled until the rotation ends, so a new request is taken only once the point is done.
//   Steps for inactive dimensions do not wait for the receiver.
//   Reset clears the accumulators, the point counter and the output valid,
//   and sets the dimension count to 8; the direction table is not cleared.
`default_nettype none
module sobol_gray_code_point_generator #(
  parameter int MAX_DIMS = sgc_pkg::DEF_MAX_DIMS,
  parameter int DIR_BITS = sgc_pkg::DEF_DIR_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sgc_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sgc_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [3:0]        cfg_data
);

  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W  = $clog2(MAX_DIMS + 1);
  localparam int BIT_W  = (DIR_BITS > 1) ? $clog2(DIR_BITS) : 1;
  localparam int ADDR_W = DIM_W + BIT_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam logic [CNT_W-1:0] LAST_J   = CNT_W'(MAX_DIMS - 1);
  localparam logic [7:0]       MAX_D8   = 8'(MAX_DIMS);
  localparam logic [6:0]       DIR_B7   = 7'(DIR_BITS);

  logic [3:0]        dims_r;
  logic              busy_r;
  logic              busy_nxt;
  logic [CNT_W-1:0]  j_r;
  logic [CNT_W-1:0]  j_nxt;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  n_nxt;
  logic [BIT_W-1:0]  c_r;
  logic              exh_r;
  logic [31:0]       cnt_r;
  logic [31:0]       cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  sgc_pkg::out_item_t out_data_r;
  sgc_pkg::out_item_t out_data_nxt;

  logic              in_acc;
  logic              do_load;
  logic              do_restart;
  logic              do_next;
  logic [31:0]       cnt_inc;
  logic [31:0]       low_zero;
  logic [BIT_W-1:0]  c_now;
  logic              exh_now;
  logic              active;
  logic              out_free;
  logic              advance;
  logic              mix_en;
  logic [CNT_W+2:0]  j_ext;
  logic [7:0]        dims_ext;

  logic [6:0]        dsel_ext;
  logic [5:0]        pos_m1;
  logic              load_ok;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       dir_word;

  logic [31:0]       cell_out [MAX_DIMS];
  sgc_pkg::cell_ctrl_t ring_ctrl;

  assign in_stall  = busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !busy_r;
  assign do_load    = in_acc && (in_data.cmd == sgc_pkg::CMD_LOAD);
  assign do_restart = in_acc && (in_data.cmd == sgc_pkg::CMD_RESTART);
  assign do_next    = in_acc && (in_data.cmd == sgc_pkg::CMD_NEXT);

  // The lowest zero bit of the counter is the one bit set in ~cnt & (cnt + 1).
  assign cnt_inc  = cnt_r + 32'd1;
  assign low_zero = ~cnt_r & cnt_inc;
  assign exh_now  = &cnt_r[DIR_BITS-1:0];

  always_comb begin
    c_now = '0;
    for (int i = 0; i < DIR_BITS; i++) begin
      if (low_zero[i]) begin
        c_now = c_now | BIT_W'(i);
      end
    end
  end

  // Clamp the configured dimension count to 1..MAX_DIMS.
  always_comb begin
    dims_ext = {4'b0000, dims_r};
    if (dims_ext == 8'd0) begin
      n_nxt = CNT_W'(1);
    end else if (dims_ext > MAX_D8) begin
      n_nxt = CNT_W'(MAX_DIMS);
    end else begin
      n_nxt = CNT_W'(dims_ext);
    end
  end

  assign active   = (j_r < n_r);
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = busy_r && (!active || out_free);
  assign mix_en   = advance && active && !exh_r;
  assign j_ext    = {3'b000, j_r};

  always_comb begin
    busy_nxt = busy_r;
    j_nxt    = j_r;
    if (do_next) begin
      busy_nxt = 1'b1;
      j_nxt    = '0;
    end else if (advance) begin
      j_nxt = j_r + CNT_W'(1);
      if (j_r == LAST_J) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_restart) begin
      cnt_nxt = '0;
    end else if (do_next && !exh_now) begin
      cnt_nxt = cnt_inc;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance && active) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.coord_dim   = j_ext[2:0];
      out_data_nxt.coord_value = cell_out[0];
      out_data_nxt.last_coord  = ((j_r + CNT_W'(1)) == n_r);
      out_data_nxt.exhausted   = exh_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r      <= sgc_pkg::DIMS_RESET;
      busy_r      <= 1'b0;
      j_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dims_r <= cfg_data;
      end
      busy_r      <= busy_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_next) begin
      n_r   <= n_nxt;
      c_r   <= c_now;
      exh_r <= exh_now;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Direction table: row per dimension, entry per bit position.
  assign dsel_ext = {4'b0000, in_data.dim_select};
  assign pos_m1   = in_data.bit_position - 6'd1;
  assign load_ok  = (dsel_ext < 7'(MAX_DIMS)) && (in_data.bit_position != 6'd0) &&
                    ({1'b0, in_data.bit_position} <= DIR_B7);
  assign wr_addr  = {dsel_ext[DIM_W-1:0], pos_m1[BIT_W-1:0]};

  // The read runs one step ahead so the word for dimension j is ready at step j.
  assign rd_addr = busy_r ? {j_nxt[DIM_W-1:0], c_r} : {DIM_W'(0), c_now};

  sgc_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_dir_table (
    .clk     (clk),
    .wr_en   (do_load && load_ok),
    .wr_addr (wr_addr),
    .wr_data (in_data.direction_word),
    .rd_addr (rd_addr),
    .rd_data (dir_word)
  );

  assign ring_ctrl.clear = do_restart;
  assign ring_ctrl.shift = advance;
  assign ring_ctrl.mix   = mix_en;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
    sgc_pkg::cell_ctrl_t ctrl_k;
    logic [31:0]         din_k;

    always_comb begin
      ctrl_k = ring_ctrl;
      if (k != 0) begin
        ctrl_k.mix = 1'b0;
      end
    end

    if (k == MAX_DIMS - 1) begin : g_tail
      assign din_k = cell_out[0];
    end else begin : g_body
      assign din_k = cell_out[k + 1];
    end

    sgc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl_k),
      .mix_word (dir_word),
      .din      (din_k),
      .dout     (cell_out[k])
    );
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sgc_checker.sv
// Port-level checks for the Sobol point generator, bound to the top level.
`default_nettype none
module sgc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire sgc_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sgc_pkg::out_item_t out_data
);

  // A reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An accepted next-point request blocks the input while the point is built.
  a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd == sgc_pkg::CMD_NEXT |=> in_stall)
    else $error("input not held during point generation");

  // Commands other than next-point do not hold the input.
  a_cmd_short: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.cmd != sgc_pkg::CMD_NEXT |=> !in_stall)
    else $error("load or restart held the input");

  // New results only come out of point generation.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a point in progress");

endmodule

bind sobol_gray_code_point_generator sgc_checker u_sgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

FILE: verif/sobol_gray_code_point_generator_test.sv
// Self-checking testbench for the Gray-code Sobol point generator.
module sobol_gray_code_point_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sgc_pkg::*;

  localparam int N_DIMS = DEF_MAX_DIMS;
  localparam int N_BITS = DEF_DIR_BITS;
  localparam int SETTLE_CYCLES = 2 * N_DIMS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_SHOWN = 10;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  // Shadow state of the generator, updated as each request is accepted.
  logic [31:0] dir_word [N_DIMS][N_BITS];
  bit word_loaded [N_DIMS][N_BITS];
  logic [31:0] accum [N_DIMS] = '{default: '0};
  logic [31:0] point_index = '0;
  logic [3:0] dims_reg = DIMS_RESET;

  out_item_t expected_coords[$];

  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int mismatch_count = 0;
  int coords_checked = 0;
  int requests_sent = 0;
  int points_sent = 0;
  int dims_writes = 0;
  int deepest_index = 0;
  int stuck_cycles = 0;

  sobol_gray_code_point_generator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int active_dims();
    if (dims_reg == 4'd0) return 1;
    if (dims_reg > N_DIMS) return N_DIMS;
    return int'(dims_reg);
  endfunction

  // Position of the lowest zero bit, one-based; N_BITS + 1 when all bits are set.
  function automatic int lowest_zero_pos(logic [31:0] v);
    int n;
    n = 1;
    while (n <= N_BITS && v[n-1]) n++;
    return n;
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, int dim, int pos, logic [31:0] word);
    in_item_t req;
    req.cmd = cmd;
    req.dim_select = dim[2:0];
    req.bit_position = pos[5:0];
    req.direction_word = word;
    return req;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) $display("%s", msg);
  endtask

  task automatic predict_request(in_item_t req);
    int n;
    int c;
    bit exh;
    out_item_t coord;
    case (req.cmd)
      CMD_LOAD: begin
        if (req.bit_position >= 1 && req.bit_position <= N_BITS) begin
          dir_word[req.dim_select][req.bit_position - 1] = req.direction_word;
          word_loaded[req.dim_select][req.bit_position - 1] = 1'b1;
        end
      end
      CMD_RESTART: begin
        foreach (accum[j]) accum[j] = '0;
        point_index = '0;
      end
      CMD_NEXT: begin
        n = active_dims();
        c = lowest_zero_pos(point_index);
        exh = (c > N_BITS);
        if (!exh) begin
          for (int j = 0; j < n; j++) accum[j] ^= dir_word[j][c - 1];
          point_index = point_index + 1;
          if (c > deepest_index) deepest_index = c;
        end
        for (int j = 0; j < n; j++) begin
          coord.coord_dim = j[2:0];
          coord.coord_value = accum[j];
          coord.last_coord = (j + 1 == n);
          coord.exhausted = exh;
          expected_coords.push_back(coord);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    predict_request(req);
  endtask

  // Holds the input idle until every coordinate has come back and the ring is at rest.
  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dims_reg = value;
    dims_writes++;
  endtask

  // Loads any direction word the coming point will use that is not yet loaded, then asks for the point.
  task automatic send_next_point();
    int c;
    int n;
    c = lowest_zero_pos(point_index);
    n = active_dims();
    if (c <= N_BITS) begin
      for (int j = 0; j < n; j++) begin
        if (!word_loaded[j][c - 1]) send_request(make_item(CMD_LOAD, j, c, $urandom));
      end
    end
    send_request(make_item(CMD_NEXT, $urandom_range(7), $urandom_range(63), $urandom));
    points_sent++;
  endtask

  task automatic test_directed_extremes();
    logic [31:0] words [N_DIMS];
    words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
              32'h8000_0000, 32'h0000_0001, $urandom, $urandom};
    for (int j = 0; j < N_DIMS; j++) send_request(make_item(CMD_LOAD, j, 1, words[j]));
    send_request(make_item(CMD_LOAD, 7, N_BITS, 32'hFFFF_FFFF));
    send_request(make_item(CMD_LOAD, 0, N_BITS, 32'h0000_0000));
    // Out-of-range positions must leave the table alone.
    send_request(make_item(CMD_LOAD, 1, 0, 32'hDEAD_BEEF));
    send_request(make_item(CMD_LOAD, 2, N_BITS + 1, 32'hDEAD_BEEF));
    send_request(make_item(CMD_LOAD, 3, 63, 32'hFFFF_FFFF));
    send_request(make_item(CMD_UNUSED, 7, 63, 32'hFFFF_FFFF));
    send_next_point();
    drain_requests();
    send_request(make_item(CMD_RESTART, 0, 0, '0));
    send_next_point();
    drain_requests();
  endtask

  task automatic test_dims_settings();
    logic [3:0] settings [5];
    settings = '{4'd0, 4'd1, 4'd15, 4'd3, 4'd8};
    foreach (settings[k]) begin
      write_dims(settings[k]);
      send_request(make_item(CMD_RESTART, $urandom_range(7), $urandom_range(63), $urandom));
      repeat (3) send_next_point();
      drain_requests();
    end
  endtask

  task automatic test_random_points(int n_items, int idle_pct, int stall_pct);
    int useful;
    int r;
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    write_dims(4'($urandom_range(15)));
    useful = 0;
    while (useful < n_items) begin
      r = $urandom_range(99);
      if (r < 50) begin
        send_next_point();
        useful++;
      end else if (r < 78) begin
        send_request(make_item(CMD_LOAD, $urandom_range(7), $urandom_range(N_BITS, 1),
                               $urandom));
        useful++;
      end else if (r < 84) begin
        send_request(make_item(CMD_RESTART, $urandom_range(7), $urandom_range(63), $urandom));
        useful++;
      end else if (r < 92) begin
        send_request(make_item(CMD_LOAD, $urandom_range(7),
                               $urandom_range(1) ? 0 : $urandom_range(63, N_BITS + 1),
                               $urandom));
      end else if (r < 97) begin
        send_request(make_item(CMD_UNUSED, $urandom_range(7), $urandom_range(63), $urandom));
      end else begin
        drain_requests();
      end
    end
    drain_requests();
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid && !out_stall) begin
      coords_checked++;
      if (expected_coords.size() == 0) begin
        flag_error($sformatf("unexpected coordinate: dim %0d value %h last %b exhausted %b",
                             out_data.coord_dim, out_data.coord_value,
                             out_data.last_coord, out_data.exhausted));
      end else begin
        exp = expected_coords.pop_front();
        if (out_data.coord_dim !== exp.coord_dim || out_data.coord_value !== exp.coord_value ||
            out_data.last_coord !== exp.last_coord || out_data.exhausted !== exp.exhausted) begin
          flag_error($sformatf(
            "coordinate %0d: dim %0d/%0d value %h/%h last %b/%b exhausted %b/%b (exp/got)",
            coords_checked, exp.coord_dim, out_data.coord_dim, exp.coord_value,
            out_data.coord_value, exp.last_coord, out_data.last_coord,
            exp.exhausted, out_data.exhausted));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("No request moved for %0d cycles, %0d coordinates still due.",
               WATCHDOG_LIMIT, expected_coords.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    out_stall_pct = 69;
    test_directed_extremes();
    test_dims_settings();
    test_random_points(40, 30, 69);
    test_random_points(40, 69, 30);
    test_random_points(40, 0, 0);
    $display("Sent %0d requests (%0d points) under %0d dimension settings.",
             requests_sent, points_sent, dims_writes);
    $display("Checked %0d coordinates; direction index reached %0d, table never exhausted.",
             coords_checked, deepest_index);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
